// ===== design/pcr_pkg.sv =====
// ---------------------------------------------------------------------------
// pcr_pkg: shared types and constants of the top-view point raster core
// widths of the bound, span and divider datapaths, register indexes, the
// request/response bundles between blocks and the jet color ramp
// ---------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

    // fixed point format of the coordinates
    localparam int FRAC_BITS      = 16;
    localparam int MAX_IMAGE_SIDE = 1024;

    localparam int COORD_W  = 32;              // input coordinate width
    localparam int DELTA_W  = COORD_W + 1;     // high - low of a bound pair
    localparam int WIDE_W   = COORD_W + 2;     // widened low bound and span
    localparam int DIFF_W   = COORD_W + 3;     // point minus widened low
    localparam int SIDE_W   = 11;              // image side register width
    localparam int PROD_W   = DIFF_W + SIDE_W + 1;
    localparam int T_FRAC_W = 16;              // fraction bits of the color parameter
    localparam int T_W      = T_FRAC_W + 1;
    localparam int PIX_W    = 10;
    localparam int COLOR_W  = 8;

    localparam int DIV_NUM_W = WIDE_W + T_FRAC_W;
    localparam int DIV_DEN_W = WIDE_W;

    localparam logic [DELTA_W-1:0] ONE_FX    = DELTA_W'(64'd1 << FRAC_BITS);
    localparam logic [DELTA_W-1:0] TINY_SPAN =
        DELTA_W'(((64'd1 << FRAC_BITS) + 64'd9999) / 64'd10000);
    // floor(n / 5) = (n * RECIP_FIVE) >> RECIP_SHIFT for any 32-bit n
    localparam logic [31:0] RECIP_FIVE  = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 34;
    localparam logic [SIDE_W-1:0] SIDE_LIMIT =
        (MAX_IMAGE_SIDE > 2047) ? SIDE_W'(2047) : SIDE_W'(MAX_IMAGE_SIDE);
    localparam logic [T_W-1:0] T_ONE = T_W'(1 << T_FRAC_W);

    // configuration registers
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [SIDE_W-1:0] IMAGE_WIDTH_RESET  = SIDE_W'(360);
    localparam logic [SIDE_W-1:0] IMAGE_HEIGHT_RESET = SIDE_W'(280);

    // operation codes
    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_DRAW    = 1'b1;

    // jet ramp offsets per channel
    localparam logic [1:0] K_RED   = 2'd3;
    localparam logic [1:0] K_GREEN = 2'd2;
    localparam logic [1:0] K_BLUE  = 2'd1;

    typedef struct packed {
        logic                      en;
        logic                      start;
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
    } meas_req_t;

    typedef struct packed {
        logic                      seen;
        logic signed [COORD_W-1:0] x_low;
        logic signed [COORD_W-1:0] x_high;
        logic signed [COORD_W-1:0] z_low;
        logic signed [COORD_W-1:0] z_high;
    } bounds_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

    // one channel of the jet ramp: clamp(1.5 - |4t - k|, 0, 1) * 255, truncated
    function automatic logic [COLOR_W-1:0] jet_channel(input logic [T_W-1:0] t,
                                                       input logic [1:0] k);
        logic signed [T_W+2:0] a;
        logic [T_W:0]          mag;
        logic signed [T_W+1:0] c;
        logic [T_W-1:0]        cc;
        logic [T_W+7:0]        p;
        a   = $signed({1'b0, t, 2'b00}) - $signed({1'b0, k, {T_FRAC_W{1'b0}}});
        mag = a[T_W+2] ? (T_W+1)'(-a) : (T_W+1)'(a);
        c   = (T_W+2)'(98304) - $signed({1'b0, mag});
        if (c[T_W+1])
            cc = '0;
        else if (c > $signed({1'b0, T_ONE}))
            cc = T_ONE;
        else
            cc = c[T_W-1:0];
        p = {cc, 8'b0} - {8'b0, cc};
        jet_channel = p[T_FRAC_W+COLOR_W-1:T_FRAC_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/pcr_div.sv =====
// ---------------------------------------------------------------------------
// pcr_div: shared iterative divider
// restoring unsigned division, one quotient bit per cycle, done pulse at end
// ---------------------------------------------------------------------------
`default_nettype none

module pcr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcr_pkg::div_req_t req,
    output pcr_pkg::div_rsp_t      rsp
);

    localparam int NUM_W = pcr_pkg::DIV_NUM_W;
    localparam int DEN_W = pcr_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] trial;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign ge      = ~trial[DEN_W+1];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== design/pcr_bounds.sv =====
// ---------------------------------------------------------------------------
// pcr_bounds: bounding box tracker
// keeps min and max of x and z over the valid measure points of one cloud
// ---------------------------------------------------------------------------
`default_nettype none

module pcr_bounds (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pcr_pkg::meas_req_t req,
    output pcr_pkg::bounds_t        bounds
);

    pcr_pkg::bounds_t bnd_reg, bnd_next;
    logic             seen_eff;

    assign seen_eff = bnd_reg.seen & ~req.start;

    always_comb
    begin
        bnd_next = bnd_reg;
        if (req.en)
        begin
            if (req.start)
                bnd_next = '0;
            if (req.valid)
            begin
                if (!seen_eff)
                begin
                    bnd_next.seen   = 1'b1;
                    bnd_next.x_low  = req.x;
                    bnd_next.x_high = req.x;
                    bnd_next.z_low  = req.z;
                    bnd_next.z_high = req.z;
                end
                else
                begin
                    if (req.x < bnd_reg.x_low)
                        bnd_next.x_low = req.x;
                    if (req.x > bnd_reg.x_high)
                        bnd_next.x_high = req.x;
                    if (req.z < bnd_reg.z_low)
                        bnd_next.z_low = req.z;
                    if (req.z > bnd_reg.z_high)
                        bnd_next.z_high = req.z;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bnd_reg <= '0;
        else
            bnd_reg <= bnd_next;
    end

    assign bounds = bnd_reg;

endmodule

`default_nettype wire

// ===== design/point_cloud_top_view_raster_core.sv =====
// ---------------------------------------------------------------------------
// point_cloud_top_view_raster_core: top-view raster of a point cloud
// measure pass tracks the bounding box, draw pass maps a point to one colored
// pixel through a sequencer around one shared iterative divider
// ---------------------------------------------------------------------------
// A measure request updates the bounding box register and leaves the sequencer
// idle. A draw request of a valid point after a measured cloud first forms the
// two 5 percent margins by a reciprocal multiply per axis, then runs up to
// three divisions on the shared restoring divider (the column, the row and the
// color parameter), with a product step ahead of the column and of the row
// division and an output step at the end; the input stays closed until the
// sequencer is back in idle. A point whose depth lies at or outside the edges
// of the widened z range skips the color division, a point that falls off the
// image ends after the row division, and an invalid point or a draw before any
// valid measure point leaves the sequencer idle and gives no pixel. A finished
// pixel waits in an output register while the next request is already taken;
// the output step stalls only while that register is still full.
`default_nettype none

module point_cloud_top_view_raster_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // stream input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // x_coord[31:0], z_coord[63:32]
    input  wire logic [2:0]  s_tuser,   // operation[0], start_of_cloud[1], point_valid[2]
    // stream output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // pixel_x[9:0], pixel_y[19:10], red[27:20],
                                        // green[35:28], blue[43:36], zero[47:44]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [pcr_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [pcr_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pcr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic             pready
);

    localparam int COORD_W    = pcr_pkg::COORD_W;
    localparam int DELTA_W    = pcr_pkg::DELTA_W;
    localparam int WIDE_W     = pcr_pkg::WIDE_W;
    localparam int DIFF_W     = pcr_pkg::DIFF_W;
    localparam int SIDE_W     = pcr_pkg::SIDE_W;
    localparam int PROD_W     = pcr_pkg::PROD_W;
    localparam int T_W        = pcr_pkg::T_W;
    localparam int T_FRAC_W   = pcr_pkg::T_FRAC_W;
    localparam int PIX_W      = pcr_pkg::PIX_W;
    localparam int NUM_W      = pcr_pkg::DIV_NUM_W;
    localparam int MRG_IN_W   = DELTA_W - 2;
    localparam int MRG_PROD_W = MRG_IN_W + 32;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_MX_GO   = 14'b00000000000010,
        S_MX_WAIT = 14'b00000000000100,
        S_MZ_GO   = 14'b00000000001000,
        S_MZ_WAIT = 14'b00000000010000,
        S_PX_MUL  = 14'b00000000100000,
        S_PX_GO   = 14'b00000001000000,
        S_PX_WAIT = 14'b00000010000000,
        S_PY_MUL  = 14'b00000100000000,
        S_PY_GO   = 14'b00001000000000,
        S_PY_WAIT = 14'b00010000000000,
        S_T_GO    = 14'b00100000000000,
        S_T_WAIT  = 14'b01000000000000,
        S_OUT     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [SIDE_W-1:0] width_reg, width_next;
    logic [SIDE_W-1:0] height_reg, height_next;

    logic signed [COORD_W-1:0] x_reg, x_next;
    logic signed [COORD_W-1:0] z_reg, z_next;
    logic signed [WIDE_W-1:0]  xl_reg, xl_next;
    logic signed [WIDE_W-1:0]  zl_reg, zl_next;
    logic [WIDE_W-1:0]         xs_reg, xs_next;
    logic [WIDE_W-1:0]         zs_reg, zs_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [DIFF_W-1:0]  dz_reg, dz_next;
    logic                      neg_reg, neg_next;
    logic                      drop_reg, drop_next;
    logic [PIX_W-1:0]          px_reg, px_next;
    logic [PIX_W-1:0]          py_reg, py_next;
    logic [T_W-1:0]            t_reg, t_next;
    logic [MRG_PROD_W-1:0]     mrg_prod_reg, mrg_prod_next;

    logic        m_valid_reg, m_valid_next;
    logic [47:0] m_data_reg, m_data_next;

    pcr_pkg::meas_req_t meas_req;
    pcr_pkg::bounds_t   bounds;
    pcr_pkg::div_req_t  div_req;
    pcr_pkg::div_rsp_t  div_rsp;

    logic              s_accept;
    logic              cfg_write;
    logic [SIDE_W-1:0] w_side, h_side, w_m1, h_m1;
    logic [DELTA_W-1:0] dx, dz, dmx, dmz, margin;
    logic [MRG_IN_W-1:0]   mrg_in;
    logic [MRG_PROD_W-1:0] mrg_prod;
    logic signed [DIFF_W-1:0] diff_x, diff_z;
    logic [PROD_W-1:0] prod_mag;
    logic              q_nonzero;
    logic              q_ge_side;
    logic [SIDE_W-1:0] side_sel;
    logic              out_free;

    // side clamp, side zero drops everything
    assign w_side = (width_reg > pcr_pkg::SIDE_LIMIT) ? pcr_pkg::SIDE_LIMIT : width_reg;
    assign h_side = (height_reg > pcr_pkg::SIDE_LIMIT) ? pcr_pkg::SIDE_LIMIT : height_reg;
    assign w_m1   = (w_side == '0) ? '0 : w_side - SIDE_W'(1);
    assign h_m1   = (h_side == '0) ? '0 : h_side - SIDE_W'(1);

    // bound spans, tiny span counts as 1.0 for the margin
    assign dx  = {bounds.x_high[COORD_W-1], bounds.x_high}
               - {bounds.x_low[COORD_W-1], bounds.x_low};
    assign dz  = {bounds.z_high[COORD_W-1], bounds.z_high}
               - {bounds.z_low[COORD_W-1], bounds.z_low};
    assign dmx = (dx < pcr_pkg::TINY_SPAN) ? pcr_pkg::ONE_FX : dx;
    assign dmz = (dz < pcr_pkg::TINY_SPAN) ? pcr_pkg::ONE_FX : dz;

    // margin = floor(d / 20) = floor((d >> 2) / 5), one shared reciprocal multiply
    assign mrg_in   = (state_reg == S_MX_GO) ? dmx[DELTA_W-1:2] : dmz[DELTA_W-1:2];
    assign mrg_prod = {32'b0, mrg_in} * {{MRG_IN_W{1'b0}}, pcr_pkg::RECIP_FIVE};
    assign margin   = DELTA_W'(mrg_prod_reg >> pcr_pkg::RECIP_SHIFT);

    assign diff_x = $signed({{(DIFF_W-COORD_W){x_reg[COORD_W-1]}}, x_reg})
                  - $signed({xl_reg[WIDE_W-1], xl_reg});
    assign diff_z = $signed({{(DIFF_W-COORD_W){z_reg[COORD_W-1]}}, z_reg})
                  - $signed({zl_reg[WIDE_W-1], zl_reg});

    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign side_sel  = (state_reg == S_PX_WAIT) ? w_side : h_side;
    assign q_nonzero = (div_rsp.quotient != '0);
    assign q_ge_side = (div_rsp.quotient >= {{(NUM_W-SIDE_W){1'b0}}, side_sel});

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = ~m_valid_reg | m_tready;

    assign meas_req.en    = s_accept & (s_tuser[0] == pcr_pkg::OP_MEASURE);
    assign meas_req.start = s_tuser[1];
    assign meas_req.valid = s_tuser[2];
    assign meas_req.x     = s_tdata[31:0];
    assign meas_req.z     = s_tdata[63:32];

    pcr_bounds u_bounds (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (meas_req),
        .bounds (bounds)
    );

    pcr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divider operands by step
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_PX_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = NUM_W'(prod_mag);
                div_req.divisor  = xs_reg;
            end
            S_PY_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = NUM_W'(prod_mag);
                div_req.divisor  = zs_reg;
            end
            S_T_GO:
            begin
                div_req.start    = ~dz_reg[DIFF_W-1] & (dz_reg != '0)
                                 & (dz_reg[WIDE_W-1:0] < zs_reg);
                div_req.dividend = {dz_reg[WIDE_W-1:0], {T_FRAC_W{1'b0}}};
                div_req.divisor  = zs_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        x_next        = x_reg;
        z_next        = z_reg;
        xl_next       = xl_reg;
        zl_next       = zl_reg;
        xs_next       = xs_reg;
        zs_next       = zs_reg;
        prod_next     = prod_reg;
        dz_next       = dz_reg;
        neg_next      = neg_reg;
        drop_next     = drop_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        t_next        = t_reg;
        mrg_prod_next = mrg_prod_reg;
        m_valid_next  = m_valid_reg & ~m_tready;
        m_data_next   = m_data_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_tuser[0] == pcr_pkg::OP_DRAW)
                    && s_tuser[2] && bounds.seen)
                begin
                    x_next     = s_tdata[31:0];
                    z_next     = s_tdata[63:32];
                    state_next = S_MX_GO;
                end
            end
            S_MX_GO:
            begin
                mrg_prod_next = mrg_prod;
                state_next    = S_MX_WAIT;
            end
            S_MX_WAIT:
            begin
                xl_next = $signed({{(WIDE_W-COORD_W){bounds.x_low[COORD_W-1]}},
                                   bounds.x_low}) - $signed({1'b0, margin});
                xs_next = {1'b0, dx} + {margin, 1'b0};
                state_next = S_MZ_GO;
            end
            S_MZ_GO:
            begin
                mrg_prod_next = mrg_prod;
                state_next    = S_MZ_WAIT;
            end
            S_MZ_WAIT:
            begin
                zl_next = $signed({{(WIDE_W-COORD_W){bounds.z_low[COORD_W-1]}},
                                   bounds.z_low}) - $signed({1'b0, margin});
                zs_next = {1'b0, dz} + {margin, 1'b0};
                state_next = S_PX_MUL;
            end
            S_PX_MUL:
            begin
                prod_next  = diff_x * $signed({1'b0, w_m1});
                state_next = S_PX_GO;
            end
            S_PX_GO:
            begin
                neg_next   = prod_reg[PROD_W-1];
                state_next = S_PX_WAIT;
            end
            S_PX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // negative quotient below one truncates to column zero
                    drop_next  = (neg_reg & q_nonzero) | q_ge_side;
                    px_next    = div_rsp.quotient[PIX_W-1:0];
                    state_next = S_PY_MUL;
                end
            end
            S_PY_MUL:
            begin
                dz_next    = diff_z;
                prod_next  = diff_z * $signed({1'b0, h_m1});
                state_next = S_PY_GO;
            end
            S_PY_GO:
            begin
                neg_next   = prod_reg[PROD_W-1];
                state_next = S_PY_WAIT;
            end
            S_PY_WAIT:
            begin
                if (div_rsp.done)
                begin
                    py_next = div_rsp.quotient[PIX_W-1:0];
                    if (drop_reg | (neg_reg & q_nonzero) | q_ge_side)
                        state_next = S_IDLE;
                    else
                        state_next = S_T_GO;
                end
            end
            S_T_GO:
            begin
                if (dz_reg[DIFF_W-1] || (dz_reg == '0))
                begin
                    t_next     = '0;
                    state_next = S_OUT;
                end
                else if (dz_reg[WIDE_W-1:0] >= zs_reg)
                begin
                    t_next     = pcr_pkg::T_ONE;
                    state_next = S_OUT;
                end
                else
                    state_next = S_T_WAIT;
            end
            S_T_WAIT:
            begin
                if (div_rsp.done)
                begin
                    t_next     = div_rsp.quotient[T_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0000,
                                    pcr_pkg::jet_channel(t_reg, pcr_pkg::K_BLUE),
                                    pcr_pkg::jet_channel(t_reg, pcr_pkg::K_GREEN),
                                    pcr_pkg::jet_channel(t_reg, pcr_pkg::K_RED),
                                    py_reg, px_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                pcr_pkg::REG_IMAGE_WIDTH:  width_next  = pwdata[SIDE_W-1:0];
                pcr_pkg::REG_IMAGE_HEIGHT: height_next = pwdata[SIDE_W-1:0];
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            pcr_pkg::REG_IMAGE_WIDTH:  prdata = pcr_pkg::CFG_DATA_W'(width_reg);
            pcr_pkg::REG_IMAGE_HEIGHT: prdata = pcr_pkg::CFG_DATA_W'(height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            width_reg   <= pcr_pkg::IMAGE_WIDTH_RESET;
            height_reg  <= pcr_pkg::IMAGE_HEIGHT_RESET;
            drop_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            drop_reg    <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        z_reg        <= z_next;
        xl_reg       <= xl_next;
        zl_reg       <= zl_next;
        xs_reg       <= xs_next;
        zs_reg       <= zs_next;
        prod_reg     <= prod_next;
        dz_reg       <= dz_next;
        neg_reg      <= neg_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        t_reg        <= t_next;
        mrg_prod_reg <= mrg_prod_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire
